### rtl/adrpid_pkg.sv
// Shared types and constants for the ADR PID spreading factor / power controller.
// Used by adrpid_div, adr_pid_sf_power_controller_top and the testbench; no dependencies.
`timescale 1ns / 1ps
package adrpid_pkg;

	// Default number of per-device state entries
	localparam int DEVICES_DEF = 256;

	// Port widths
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KP         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KI         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KD         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SNR_FLOOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SNR_STEP   = 3'd4;

	// Configuration reset values
	localparam logic [11:0] KP_RST        = 12'd128;
	localparam logic [11:0] KI_RST        = 12'd0;
	localparam logic [11:0] KD_RST        = 12'd0;
	localparam logic [10:0] SNR_FLOOR_RST = 11'h6C0;	// -320
	localparam logic [7:0]  SNR_STEP_RST  = 8'd40;

	// Radio limits
	localparam logic [3:0] SF_MIN = 4'd7;
	localparam logic [3:0] SF_MAX = 4'd12;
	localparam logic [3:0] TP_MIN = 4'd2;
	localparam logic [3:0] TP_MAX = 4'd14;

	// Milliseconds per second: integral scale and elapsed time fallback
	localparam logic [31:0] MS_PER_S = 32'd1000;

	// Internal datapath widths
	localparam int ERR_W  = 13;	// required minus measured SNR
	localparam int DIFF_W = 14;	// error change since last item
	localparam int T_W    = 25;	// gain times error magnitude
	localparam int P_W    = 26;	// proportional term, signed
	localparam int INC_W  = 48;	// integral increment, signed
	localparam int D_W    = 36;	// derivative term, signed
	localparam int U_W    = 40;	// controller output, signed
	localparam int R_W    = 28;	// rounded step magnitude
	localparam int WORD_W = 80;	// {integral_sum, last_error, last_time}

	// Shared divider: radix 4, two quotient bits per cycle
	localparam int DIVD_W = 58;
	localparam int DIVS_W = 32;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEPS_I = 5'd29;	// 58-bit dividend
	localparam logic [STEP_W-1:0] STEPS_D = 5'd18;	// 36-bit dividend, left aligned
	localparam int D_PAD_W = DIVD_W - 36;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MP,
		ST_MI1,
		ST_MI2,
		ST_DI,
		ST_MD1,
		ST_MD2,
		ST_DD,
		ST_INT,
		ST_SUM,
		ST_ABS,
		ST_RND
	} state_t;

endpackage

### rtl/adr_pid_sf_power_controller_top.sv
// Per-device ADR PID controller: SNR error to spreading factor and transmit power.
// Depends on adrpid_pkg and adrpid_div.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------
//  cfg      | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  s_axis   | in        | s_tvalid / s_tready     | s_tdata: one uplink observation
//  m_axis   | out       | m_tvalid / m_tready     | m_tdata: new data rate and power
//
// Each item passes through a dozen sequencer steps around one shared 32x32 multiplier, and
// the shared radix-4 divider performs both the integral scaling and the derivative division;
// the sequencer waits in ST_DI and ST_DD until the divider is no longer busy.
// s_tready is high only while the sequencer is idle; a finished result sits in the output
// register, and the next item may be taken while it waits.
// Reset restores default configuration and zero device state; cfg_ready is always high.
`timescale 1ns / 1ps
module adr_pid_sf_power_controller_top #(
	parameter int DEVICES = adrpid_pkg::DEVICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [adrpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adrpid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// device_id[7:0], current_sf[11:8], current_tx_power[15:12], avg_snr[26:16],
	// now_ms[58:27], zero fill[63:59]
	input  logic [adrpid_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// new_data_rate[2:0], new_tx_power[6:3], zero fill[7]
	output logic [adrpid_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import adrpid_pkg::*;

	localparam int IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	// Configuration
	logic [11:0] kp_q, ki_q, kd_q;
	logic [10:0] floor_q;
	logic [7:0]  step_q;

	// Sequencer
	state_t   state_q, state_d;
	div_cmd_t div_cmd;
	logic     div_busy;
	logic [DIVD_W-1:0] div_quot;
	logic     mem_we;
	logic     out_load;

	// Item registers
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       sf_q, tp_q;
	logic [10:0]      snr_q;
	logic [31:0]      now_q;
	logic [WORD_W-1:0] rd_q;
	logic             rd_vld_q;

	// Per-device state memory with reset valid bits
	logic [WORD_W-1:0] mem [DEVICES];
	logic [DEVICES-1:0] vld_q;
	logic [IDX_W-1:0]  idx_tab [256];

	// Working registers
	logic [ERR_W-1:0]  err_q;
	logic [11:0]       err_mag_q;
	logic [12:0]       diff_mag_q;
	logic              diff_neg_q;
	logic [31:0]       dt_q;
	logic [31:0]       iold_q;
	logic [P_W-1:0]    p_q;
	logic [T_W-1:0]    t_q;
	logic [INC_W-1:0]  inc_q;
	logic [D_W-1:0]    d_q;
	logic [31:0]       integ_q;
	logic [U_W-1:0]    u_q;
	logic              neg_q;
	logic [R_W-1:0]    rm_q;

	// Output register
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// Input field views
	logic [7:0]  in_id;
	logic [3:0]  in_sf, in_sf_c;
	assign in_id = s_tdata[7:0];
	assign in_sf = s_tdata[11:8];

	always_comb begin
		if (in_sf < SF_MIN) begin
			in_sf_c = SF_MIN;
		end else if (in_sf > SF_MAX) begin
			in_sf_c = SF_MAX;
		end else begin
			in_sf_c = in_sf;
		end
	end

	// device_id modulo DEVICES as a constant table
	for (genvar k = 0; k < 256; k++) begin : g_idx
		assign idx_tab[k] = IDX_W'(k % DEVICES);
	end

	// Load-step arithmetic
	logic [2:0]        dr_cur;
	logic [10:0]       step_prod;
	logic [ERR_W-1:0]  req, err;
	logic [31:0]       ent_integ, ent_time;
	logic [15:0]       ent_lerr;
	logic [16:0]       diff17;
	logic [DIFF_W-1:0] diff;
	logic [ERR_W-1:0]  err_negd;
	logic [DIFF_W-1:0] diff_negd;
	logic [31:0]       dt;

	always_comb begin
		dr_cur    = 3'(SF_MAX - sf_q);
		step_prod = {3'b0, step_q} * {8'b0, dr_cur};
		req       = {{2{floor_q[10]}}, floor_q} + {2'b0, step_prod};
		err       = req - {{2{snr_q[10]}}, snr_q};
		ent_integ = rd_vld_q ? rd_q[79:48] : '0;
		ent_lerr  = rd_vld_q ? rd_q[47:32] : '0;
		ent_time  = rd_vld_q ? rd_q[31:0]  : '0;
		diff17    = {{4{err[ERR_W-1]}}, err} - {ent_lerr[15], ent_lerr};
		diff      = diff17[DIFF_W-1:0];
		err_negd  = -err;
		diff_negd = -diff;
		dt        = (now_q > ent_time) ? (now_q - ent_time) : MS_PER_S;
	end

	// Shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	always_comb begin
		case (state_q)
			ST_MP: begin
				mul_a = {20'b0, kp_q};
				mul_b = {20'b0, err_mag_q};
			end
			ST_MI1: begin
				mul_a = {20'b0, ki_q};
				mul_b = {20'b0, err_mag_q};
			end
			ST_MI2: begin
				mul_a = {7'b0, t_q};
				mul_b = dt_q;
			end
			ST_MD1: begin
				mul_a = {20'b0, kd_q};
				mul_b = {19'b0, diff_mag_q};
			end
			ST_MD2: begin
				mul_a = {7'b0, t_q};
				mul_b = MS_PER_S;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = {32'b0, mul_a} * {32'b0, mul_b};
	end

	// Integral saturation, sum, rounding and clamping
	logic [49:0]  isum;
	logic         ovf_pos, ovf_neg;
	logic [31:0]  integ_sat;
	logic [U_W-1:0] u_sum, u_mag, u_rnd;
	logic [29:0]  r30, sfs, tps;
	logic [3:0]   nsf, ntp;
	logic [2:0]   dr_new;

	always_comb begin
		isum      = {{18{iold_q[31]}}, iold_q} + {{2{inc_q[INC_W-1]}}, inc_q};
		ovf_pos   = !isum[49] && (isum[48:31] != '0);
		ovf_neg   = isum[49] && (isum[48:31] != '1);
		integ_sat = ovf_pos ? 32'h7FFF_FFFF : (ovf_neg ? 32'h8000_0000 : isum[31:0]);

		u_sum = {{(U_W-P_W){p_q[P_W-1]}}, p_q} + {{(U_W-32){integ_q[31]}}, integ_q}
			+ {{(U_W-D_W){d_q[D_W-1]}}, d_q};

		u_mag = u_q[U_W-1] ? -u_q : u_q;
		u_rnd = u_mag + U_W'(2048);

		r30 = neg_q ? -{2'b0, rm_q} : {2'b0, rm_q};
		sfs = {26'b0, sf_q} + r30;
		tps = {26'b0, tp_q} + r30;
		if ($signed(sfs) < $signed({26'b0, SF_MIN})) begin
			nsf = SF_MIN;
		end else if ($signed(sfs) > $signed({26'b0, SF_MAX})) begin
			nsf = SF_MAX;
		end else begin
			nsf = sfs[3:0];
		end
		if ($signed(tps) < $signed({26'b0, TP_MIN})) begin
			ntp = TP_MIN;
		end else if ($signed(tps) > $signed({26'b0, TP_MAX})) begin
			ntp = TP_MAX;
		end else begin
			ntp = tps[3:0];
		end
		dr_new = 3'(SF_MAX - nsf);
	end

	// Sequencer: next state and control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		div_cmd  = '0;
		mem_we   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: state_d = ST_MP;
			ST_MP:   state_d = ST_MI1;
			ST_MI1:  state_d = ST_MI2;
			ST_MI2: begin
				div_cmd.start    = 1'b1;
				div_cmd.steps    = STEPS_I;
				div_cmd.dividend = prod[DIVD_W-1:0];
				div_cmd.divisor  = MS_PER_S;
				state_d          = ST_DI;
			end
			ST_DI: begin
				if (!div_busy) begin
					state_d = ST_MD1;
				end
			end
			ST_MD1: state_d = ST_MD2;
			ST_MD2: begin
				div_cmd.start    = 1'b1;
				div_cmd.steps    = STEPS_D;
				div_cmd.dividend = {prod[35:0], {D_PAD_W{1'b0}}};
				div_cmd.divisor  = dt_q;
				state_d          = ST_DD;
			end
			ST_DD: begin
				if (!div_busy) begin
					state_d = ST_INT;
				end
			end
			ST_INT: begin
				mem_we  = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_ABS;
			ST_ABS: state_d = ST_RND;
			ST_RND: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	adrpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= KP_RST;
			ki_q    <= KI_RST;
			kd_q    <= KD_RST;
			floor_q <= SNR_FLOOR_RST;
			step_q  <= SNR_STEP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KP:        kp_q    <= cfg_data;
				CFG_KI:        ki_q    <= cfg_data;
				CFG_KD:        kd_q    <= cfg_data;
				CFG_SNR_FLOOR: floor_q <= cfg_data[10:0];
				CFG_SNR_STEP:  step_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// State memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= {integ_sat, {{(16-ERR_W){err_q[ERR_W-1]}}, err_q}, now_q};
		end
		if (s_tvalid && s_tready) begin
			rd_q <= mem[idx_tab[in_id]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (s_tvalid && s_tready) begin
				rd_vld_q <= vld_q[idx_tab[in_id]];
			end
		end
	end

	// Datapath registers, advanced by state
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					idx_q <= idx_tab[in_id];
					sf_q  <= in_sf_c;
					tp_q  <= s_tdata[15:12];
					snr_q <= s_tdata[26:16];
					now_q <= s_tdata[58:27];
				end
			end
			ST_LOAD: begin
				err_q      <= err;
				err_mag_q  <= err[ERR_W-1] ? err_negd[11:0] : err[11:0];
				diff_neg_q <= diff[DIFF_W-1];
				diff_mag_q <= diff[DIFF_W-1] ? diff_negd[12:0] : diff[12:0];
				dt_q       <= dt;
				iold_q     <= ent_integ;
			end
			ST_MP: begin
				p_q <= err_q[ERR_W-1] ? -prod[P_W-1:0] : prod[P_W-1:0];
			end
			ST_MI1: t_q <= prod[T_W-1:0];
			ST_DI: begin
				inc_q <= err_q[ERR_W-1] ? -{1'b0, div_quot[INC_W-2:0]}
					: {1'b0, div_quot[INC_W-2:0]};
			end
			ST_MD1: t_q <= prod[T_W-1:0];
			ST_DD: begin
				d_q <= diff_neg_q ? -{1'b0, div_quot[D_W-2:0]} : {1'b0, div_quot[D_W-2:0]};
			end
			ST_INT: integ_q <= integ_sat;
			ST_SUM: u_q <= u_sum;
			ST_ABS: begin
				neg_q <= u_q[U_W-1];
				rm_q  <= u_rnd[U_W-1:12];
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, ntp, dr_new};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q == ST_LOAD)
		else $error("accepted item did not enter the load step");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_RND)
		else $error("result appeared outside the rounding step");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_cmd.start |-> !div_busy)
		else $error("divider started while busy");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == ST_SUM && !mem_we))
		else $error("device state written more than once per item");

endmodule

### rtl/adrpid_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on adrpid_pkg (div_cmd_t, DIVD_W, DIVS_W, STEP_W).
`timescale 1ns / 1ps
module adrpid_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adrpid_pkg::div_cmd_t          cmd,
	output logic                          busy,
	output logic [adrpid_pkg::DIVD_W-1:0] quotient
);
	import adrpid_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVD_W-1:0] quot_q;
	logic [DIVS_W:0]   s1;
	logic [DIVS_W:0]   s2;

	// One restoring step: returns {quotient bit, new remainder}
	function automatic logic [DIVS_W:0] rstep(input logic [DIVS_W-1:0] r, input logic b,
		input logic [DIVS_W-1:0] d);
		logic [DIVS_W:0] t;
		logic            ge;
		t  = {r, b};
		ge = (t >= {1'b0, d});
		return {ge, ge ? DIVS_W'(t - {1'b0, d}) : t[DIVS_W-1:0]};
	endfunction

	always_comb begin
		s1 = rstep(rem_q, quot_q[DIVD_W-1], dvs_q);
		s2 = rstep(s1[DIVS_W-1:0], quot_q[DIVD_W-2], dvs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift dividend out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q  <= '0;
			dvs_q  <= cmd.divisor;
			quot_q <= cmd.dividend;
		end else if (busy_q) begin
			rem_q  <= s2[DIVS_W-1:0];
			quot_q <= {quot_q[DIVD_W-3:0], s1[DIVS_W], s2[DIVS_W]};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> busy_q)
		else $error("divider did not go busy after start");

	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q == STEP_W'(1) && !cmd.start) |=> !busy_q)
		else $error("divider ran past its step count");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < dvs_q))
		else $error("partial remainder not below divisor");

endmodule

### tb/adr_pid_checker.sv
// Scoreboard for the ADR PID controller: tracks register writes, predicts the new
// data rate and transmit power for every accepted observation and checks the results.
// Depends on adrpid_pkg.
`timescale 1ns / 1ps
module adr_pid_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [adrpid_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [adrpid_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [adrpid_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [adrpid_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                                 errors,
	output int                                 pending
);
	import adrpid_pkg::*;

	typedef struct packed {
		logic [2:0] rate;
		logic [3:0] power;
	} adr_cmd_t;

	// controller settings and per-device loop state
	longint gain_p, gain_i, gain_d, snr_floor, snr_step;
	int      integ_sum [DEVICES_DEF];
	shortint prev_err  [DEVICES_DEF];
	logic [31:0] prev_time [DEVICES_DEF];

	adr_cmd_t decisions [$];
	int       results_seen;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// one PID update of the addressed device; returns the new rate and power
	function automatic adr_cmd_t pid_decide(input logic [IN_TDATA_W-1:0] obs);
		logic [7:0]  dev;
		logic [31:0] now;
		longint sf, tp, snr, dt, req, err, p, integ, d, u, mag, r;
		adr_cmd_t res;
		dev = obs[7:0];
		sf  = clip(longint'(obs[11:8]), longint'(SF_MIN), longint'(SF_MAX));
		tp  = longint'(obs[15:12]);
		snr = $signed(obs[26:16]);
		now = obs[58:27];
		// zero, negative or wrapped elapsed time counts as one second
		if (now > prev_time[dev])
			dt = longint'(now - prev_time[dev]);
		else
			dt = longint'(MS_PER_S);
		req = snr_floor + snr_step * (longint'(SF_MAX) - sf);
		err = req - snr;
		p = gain_p * err;
		integ = longint'(integ_sum[dev]) + (gain_i * err * dt) / longint'(MS_PER_S);
		integ = clip(integ, -(longint'(1) << 31), (longint'(1) << 31) - 1);
		integ_sum[dev] = int'(integ);
		d = (gain_d * (err - longint'(prev_err[dev])) * longint'(MS_PER_S)) / dt;
		u = p + integ + d;
		// round to whole steps, halves away from zero
		mag = (u < 0) ? -u : u;
		r = (mag + 2048) >> 12;
		if (u < 0)
			r = -r;
		prev_err[dev]  = shortint'(err);
		prev_time[dev] = now;
		res.rate  = 3'(longint'(SF_MAX) - clip(sf + r, longint'(SF_MIN), longint'(SF_MAX)));
		res.power = 4'(clip(tp + r, longint'(TP_MIN), longint'(TP_MAX)));
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		adr_cmd_t want, got;
		if (!arst_n) begin
			gain_p    = KP_RST;
			gain_i    = KI_RST;
			gain_d    = KD_RST;
			snr_floor = $signed(SNR_FLOOR_RST);
			snr_step  = SNR_STEP_RST;
			for (int i = 0; i < DEVICES_DEF; i++) begin
				integ_sum[i] = 0;
				prev_err[i]  = 0;
				prev_time[i] = '0;
			end
			decisions.delete();
			results_seen = 0;
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KP:        gain_p = cfg_data;
					CFG_KI:        gain_i = cfg_data;
					CFG_KD:        gain_d = cfg_data;
					CFG_SNR_FLOOR: snr_floor = $signed(cfg_data[10:0]);
					CFG_SNR_STEP:  snr_step = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.rate  = m_tdata[2:0];
				got.power = m_tdata[6:3];
				if (decisions.size() == 0) begin
					if (errors < 10)
						$display("%0t: result %0d arrived with nothing outstanding: rate %0d power %0d",
							$realtime, results_seen, got.rate, got.power);
					errors++;
				end else begin
					want = decisions.pop_front();
					if (got.rate !== want.rate || got.power !== want.power) begin
						if (errors < 10)
							$display("%0t: result %0d mismatch: expected rate %0d power %0d, got rate %0d power %0d",
								$realtime, results_seen, want.rate, want.power, got.rate, got.power);
						errors++;
					end
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				decisions.push_back(pid_decide(s_tdata));
			pending <= decisions.size();
		end
	end

endmodule

### tb/tb_adr_pid_sf_power_controller_top.sv
// Testbench top for adr_pid_sf_power_controller_top: drives register writes and uplink
// observations under varying back-pressure and reports the verdict.
// Depends on adrpid_pkg, the controller RTL and adr_pid_checker.
`timescale 1ns / 1ps
module tb_adr_pid_sf_power_controller_top;
	import adrpid_pkg::*;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int errors, pending;
	int send_idle = 0;
	int stall_pct = 0;
	int floor_now = -320;
	int step_now  = 40;
	logic [31:0] dev_clock [DEVICES_DEF];

	always #1 clk = ~clk;

	adr_pid_sf_power_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	adr_pid_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// hold valid until the register transfer; the caller drops it after the last one
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic write_gains(input int kp, input int ki, input int kd, input int flr,
			input int stp);
		put_reg(CFG_KP, 12'(kp));
		put_reg(CFG_KI, 12'(ki));
		put_reg(CFG_KD, 12'(kd));
		put_reg(CFG_SNR_FLOOR, {1'b0, 11'(flr)});
		put_reg(CFG_SNR_STEP, 12'(stp));
		cfg_valid <= 1'b0;
		floor_now = flr;
		step_now  = stp;
	endtask

	task automatic send_obs(input logic [7:0] dev, input logic [3:0] sf, input logic [3:0] tp,
			input int snr, input logic [31:0] now);
		int gap;
		gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 80) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, now, 11'(snr), tp, sf, dev};
		do @(posedge clk); while (!s_tready);
		dev_clock[dev] = now;
	endtask

	// drop valid and wait for every outstanding decision to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int          sel, sfc, req, snr, kp, ki, kd, flr, stp;
		logic [7:0]  dev;
		logic [3:0]  sf, tp;
		logic [31:0] now, t;
		for (int i = 0; i < DEVICES_DEF; i++)
			dev_clock[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: timestamp fallbacks, field extremes, integral saturation both ways
		write_gains(128, 4095, 4095, -320, 40);
		send_obs(8'd0,   4'd7,  4'd14, 0,     32'd0);
		send_obs(8'd0,   4'd12, 4'd2,  -640,  32'd0);
		send_obs(8'd0,   4'd10, 4'd8,  640,   32'd1);
		send_obs(8'd255, 4'd0,  4'd0,  -1024, 32'hFFFF_FFFF);
		send_obs(8'd255, 4'd15, 4'd15, 1023,  32'd5);
		send_obs(8'd255, 4'd13, 4'd1,  100,   32'd5000);
		send_obs(8'd1,   4'd8,  4'd15, -200,  32'd1000);
		send_obs(8'd1,   4'd9,  4'd3,  -150,  32'd1500);
		send_obs(8'd2,   4'd12, 4'd14, -640,  32'hFFFF_FFFE);
		send_obs(8'd2,   4'd12, 4'd14, -640,  32'hFFFF_FFFF);
		send_obs(8'd2,   4'd7,  4'd2,  640,   32'd0);
		send_obs(8'd3,   4'd7,  4'd2,  1023,  32'hFFFF_FFFE);
		send_obs(8'd3,   4'd7,  4'd2,  1023,  32'hFFFF_FFFF);
		send_obs(8'd3,   4'd11, 4'd6,  -500,  32'd100);
		send_obs(8'd170, 4'd5,  4'd10, 341,   32'h5555_5555);
		send_obs(8'd85,  4'd10, 4'd5,  -342,  32'hAAAA_AAAA);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 74; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 74; end
				default: begin send_idle = 19; stall_pct = 19; end
			endcase
			case (ph)
				0: begin kp = 4095; ki = 4095; kd = 4095; flr = 640;  stp = 255; end
				1: begin kp = 0;    ki = 0;    kd = 0;    flr = -640; stp = 0;   end
				// gain of one half puts odd errors exactly on a half step
				2: begin kp = 2048; ki = 0;    kd = 0;    flr = -320; stp = 40;  end
				3: begin
					kp = $urandom_range(0, 4095);
					ki = $urandom_range(0, 4095);
					kd = $urandom_range(0, 4095);
					flr = int'($urandom_range(0, 1280)) - 640;
					stp = $urandom_range(0, 255);
				end
				default: begin
					kp = $urandom_range(0, 1024);
					ki = $urandom_range(0, 300);
					kd = $urandom_range(0, 64);
					flr = int'($urandom_range(0, 1280)) - 640;
					stp = $urandom_range(0, 255);
				end
			endcase
			write_gains(kp, ki, kd, flr, stp);

			for (int n = 0; n < 180; n++) begin
				// a few busy devices carry most of the traffic
				dev = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom);
				sf  = ($urandom_range(99) < 90) ? 4'($urandom_range(7, 12)) : 4'($urandom);
				tp  = ($urandom_range(99) < 90) ? 4'($urandom_range(2, 14)) : 4'($urandom);
				sfc = (sf < SF_MIN) ? SF_MIN : (sf > SF_MAX) ? SF_MAX : sf;
				req = floor_now + step_now * (SF_MAX - sfc);

				// mostly near the required SNR so the loop settles instead of pinning
				sel = $urandom_range(99);
				if (sel < 70)
					snr = req + int'($urandom_range(0, 96)) - 48;
				else if (sel < 90)
					snr = int'($urandom_range(0, 1280)) - 640;
				else
					snr = int'($urandom_range(0, 2047)) - 1024;
				if (snr > 1023)
					snr = 1023;
				else if (snr < -1024)
					snr = -1024;

				t = dev_clock[dev];
				sel = $urandom_range(99);
				if (sel < 68)
					now = t + $urandom_range(1, 3000);
				else if (sel < 76)
					now = t;
				else if (sel < 84)
					now = t - $urandom_range(0, 5000);
				else if (sel < 90)
					now = $urandom;
				else if (sel < 95)
					now = t + 1;
				else
					now = 32'hFFFF_FFFF - $urandom_range(0, 2000);

				send_obs(dev, sf, tp, snr, now);
			end
			drain();
		end

		repeat (80) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_adr_pid_sf_power_controller_top: done, clean");
		else
			$display("tb_adr_pid_sf_power_controller_top: done, errors");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_adr_pid_sf_power_controller_top: done, errors");
		$finish;
	end

endmodule
